// ----- hdl/assert_macros.svh -----
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a on this edge implies c on the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

// a implies c on the same edge
`define ASSERT_SAME(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

`endif

// ----- hdl/srg_pkg.sv -----
// types and constants of the scheduled ramp generator
// no dependencies
`timescale 1ns / 1ps

package srg_pkg;

	localparam int VAL_W = 48;
	localparam int MAG_W = 49;
	localparam int MPS_W = 24;
	localparam logic [MPS_W-1:0] MPS_RESET = 24'd1365;
	localparam int FIFO_DEPTH = 2;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_SCHED = 2'd1;
	localparam logic [1:0] MODE_STOP = 2'd2;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_SCHED,
		CMD_JUMP,
		CMD_STOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic signed [31:0] target;
		logic [30:0] ramp;
		logic [30:0] delay;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_state_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_EXEC,
		BK_SEND,
		BK_SRCH,
		BK_SCMP,
		BK_TCHK,
		BK_TRD,
		BK_TSEG,
		BK_TS1,
		BK_TW1,
		BK_TS2,
		BK_TW2,
		BK_TPOP,
		BK_TEND,
		BK_TOUT
	} bk_state_t;

endpackage

// ----- hdl/scheduled_ramp_generator.sv -----
// Scheduled ramp generator. A sample tick (mode 0) produces one output word
// after all segments starting inside that sample period have been applied;
// scheduling (mode 1) and stop (mode 2) words produce no output. A tick steps
// through the back-end states IDLE, EXEC, TCHK, TRD (when segments are
// pending), TEND and TOUT, plus any wait for the output register to free up;
// each segment with a nonzero ramp that starts in the tick adds two passes of
// the serial multiply-divide unit and its bookkeeping. A schedule word walks
// the pending store one entry at a time, a search step then a compare step.
// A two-word queue lets input words be taken while the back end works and
// while an output word waits. No clearing pass is needed after reset.
// depends on srg_pkg, srg_front, srg_fifo, srg_back
`timescale 1ns / 1ps

module scheduled_ramp_generator #(
	parameter int MAX_SEGMENTS = 16,
	parameter int TIME_WIDTH = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [23:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic signed [31:0] target_value,
	input  logic signed [31:0] ramp_time,
	input  logic signed [31:0] delay_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] sample_value,
	output logic               ramping,
	output logic               overflow
);

	import srg_pkg::*;

	logic [MPS_W-1:0] mps_q;
	fifo_stat_t fifo_stat;
	cmd_t push_cmd, head_cmd;
	logic push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mps_q <= MPS_RESET;
		end else if (cfg_we) begin
			mps_q <= cfg_wdata;
		end
	end

	srg_front u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.target_value(target_value),
		.ramp_time(ramp_time),
		.delay_time(delay_time),
		.fifo_stat(fifo_stat),
		.push(push),
		.push_cmd(push_cmd)
	);

	srg_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.head_cmd(head_cmd),
		.stat(fifo_stat)
	);

	srg_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .TIME_WIDTH(TIME_WIDTH)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.ms_per_sample(mps_q),
		.head_cmd(head_cmd),
		.fifo_stat(fifo_stat),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_value(sample_value),
		.ramping(ramping),
		.overflow(overflow)
	);

endmodule

// ----- hdl/srg_ram.sv -----
// generic simple dual port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module srg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/srg_front.sv -----
// front end: accepts input words, decodes mode and clamps times
// depends on srg_pkg
`timescale 1ns / 1ps

module srg_front (
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic signed [31:0]  target_value,
	input  logic signed [31:0]  ramp_time,
	input  logic signed [31:0]  delay_time,
	input  srg_pkg::fifo_stat_t fifo_stat,
	output logic                push,
	output srg_pkg::cmd_t       push_cmd
);

	import srg_pkg::*;

	logic known;

	assign in_stall = fifo_stat.full;

	always_comb begin
		known = 1'b1;
		push_cmd.target = target_value;
		push_cmd.ramp = ramp_time[31] ? 31'd0 : ramp_time[30:0];
		push_cmd.delay = delay_time[31] ? 31'd0 : delay_time[30:0];
		case (mode)
			MODE_TICK:  push_cmd.kind = CMD_TICK;
			MODE_SCHED: push_cmd.kind = delay_time[31] ? CMD_JUMP : CMD_SCHED;
			MODE_STOP:  push_cmd.kind = CMD_STOP;
			default: begin
				push_cmd.kind = CMD_STOP;
				known = 1'b0;
			end
		endcase
	end

	// unused mode is taken and dropped
	assign push = in_valid && !fifo_stat.full && known;

endmodule

// ----- hdl/srg_fifo.sv -----
// short command queue between front and back end
// depends on srg_pkg
`timescale 1ns / 1ps

module srg_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  srg_pkg::cmd_t       push_cmd,
	input  logic                pop,
	output srg_pkg::cmd_t       head_cmd,
	output srg_pkg::fifo_stat_t stat
);

	import srg_pkg::*;

	cmd_t mem_q [FIFO_DEPTH];
	logic [$clog2(FIFO_DEPTH)-1:0] wr_q, rd_q;
	logic [$clog2(FIFO_DEPTH+1)-1:0] cnt_q;
	logic do_push, do_pop;

	assign stat.full = (cnt_q == FIFO_DEPTH[$clog2(FIFO_DEPTH+1)-1:0]);
	assign stat.empty = (cnt_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign head_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/srg_mdiv.sv -----
// serial multiply then divide: min(floor(mag * num / den), 2^48)
// shift-add multiply, then restoring division one bit per cycle; depends on srg_pkg
`timescale 1ns / 1ps

module srg_mdiv #(
	parameter int TIME_WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [srg_pkg::MAG_W-1:0] mag,
	input  logic [TIME_WIDTH-1:0]    num,
	input  logic [TIME_WIDTH-1:0]    den,
	output logic                     done,
	output logic [srg_pkg::MAG_W-1:0] quot
);

	import srg_pkg::*;

	localparam int TW = TIME_WIDTH;
	localparam int PW = MAG_W + TW;
	localparam int NW = $clog2(PW + 1);
	localparam logic [MAG_W:0] QLIM = {2'b01, {(MAG_W-1){1'b0}}};

	md_state_t state_q, state_d;
	logic [PW:0] prod_q;
	logic [TW-1:0] den_q, rem_q;
	logic [MAG_W-1:0] mag_q;
	logic [MAG_W:0] q_q;
	logic big_q;
	logic done_q;
	logic [NW-1:0] cnt_q;
	logic [MAG_W:0] hi_sum;
	logic [TW:0] rs;
	logic [TW:0] rdiff;
	logic last;

	assign hi_sum = prod_q[PW:TW] + (prod_q[0] ? {1'b0, mag_q} : '0);
	assign rs = {rem_q, prod_q[PW-1]};
	assign rdiff = rs - {1'b0, den_q};
	assign last = (cnt_q == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			MD_IDLE: if (start) state_d = MD_MUL;
			MD_MUL:  if (last) state_d = MD_DIV;
			MD_DIV:  if (last) state_d = MD_IDLE;
			default: state_d = MD_IDLE;
		endcase
	end

	// quotient is complete the cycle after the last division step
	assign done = done_q;
	assign quot = (big_q || q_q > QLIM) ? QLIM[MAG_W-1:0] : q_q[MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == MD_DIV) && last;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (start) begin
					prod_q <= {{(MAG_W+1){1'b0}}, num};
					mag_q <= mag;
					den_q <= den;
					cnt_q <= NW'(TW - 1);
				end
			end
			MD_MUL: begin
				prod_q <= {1'b0, hi_sum, prod_q[TW-1:1]};
				cnt_q <= cnt_q - 1'b1;
				if (last) begin
					cnt_q <= NW'(PW - 1);
					rem_q <= '0;
					q_q <= '0;
					big_q <= 1'b0;
				end
			end
			MD_DIV: begin
				prod_q <= {prod_q[PW-1:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				big_q <= big_q | q_q[MAG_W];
				if (rs >= {1'b0, den_q}) begin
					rem_q <= rdiff[TW-1:0];
					q_q <= {q_q[MAG_W-1:0], 1'b1};
				end else begin
					rem_q <= rs[TW-1:0];
					q_q <= {q_q[MAG_W-1:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hdl/srg_back.sv -----
// back end: segment store, schedule insert, per-tick segment processing
// depends on srg_pkg, srg_ram, srg_mdiv
`timescale 1ns / 1ps

module srg_back #(
	parameter int MAX_SEGMENTS = 16,
	parameter int TIME_WIDTH = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [srg_pkg::MPS_W-1:0]   ms_per_sample,
	input  srg_pkg::cmd_t               head_cmd,
	input  srg_pkg::fifo_stat_t         fifo_stat,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [31:0]          sample_value,
	output logic                        ramping,
	output logic                        overflow
);

	import srg_pkg::*;

	localparam int TW = TIME_WIDTH;
	localparam int AW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int EW = 2 * TW + 32;
	localparam logic [TW-1:0] TNEVER = '1;
	localparam logic [TW-1:0] TLIM = TNEVER - 1'b1;
	localparam logic [CW-1:0] CMAX = CW'(MAX_SEGMENTS);

	function automatic logic [TW-1:0] tadd(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [TW-1:0] ac;
		logic [TW:0] s;
		ac = (a > TLIM) ? TLIM : a;
		s = {1'b0, ac} + {1'b0, b};
		return (s > {1'b0, TLIM}) ? TLIM : s[TW-1:0];
	endfunction

	function automatic logic signed [VAL_W-1:0] sat48(input logic signed [VAL_W+1:0] v);
		logic signed [VAL_W+1:0] vmax, vmin;
		vmax = {3'b000, {(VAL_W-1){1'b1}}};
		vmin = {3'b111, {(VAL_W-1){1'b0}}};
		if (v > vmax) begin
			return vmax[VAL_W-1:0];
		end else if (v < vmin) begin
			return vmin[VAL_W-1:0];
		end
		return v[VAL_W-1:0];
	endfunction

	bk_state_t state_q, state_d;
	cmd_t cmd_q;
	logic [CW-1:0] count_q, p_q;
	logic [AW-1:0] head_q;
	logic [TW-1:0] start_q, end_q, tnext_q, now_q, aet_q;
	logic [TW-1:0] seg_s_q, seg_e_q;
	logic signed [31:0] seg_t_q, at_q;
	logic signed [VAL_W-1:0] f_q, inc_q, cur_q, step_q;
	logic [MAG_W-1:0] mag_q;
	logic neg_q, ovf_q, ovf_out_q;
	logic out_valid_q, ramping_q;
	logic signed [31:0] sample_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	logic [TW-1:0] rd_s, rd_e;
	logic signed [31:0] rd_t;
	logic brk;
	logic md_start, md_done;
	logic [TW-1:0] md_num;
	logic [MAG_W-1:0] md_q;
	logic signed [VAL_W+1:0] md_sq;
	logic signed [MAG_W-1:0] diff;
	logic signed [VAL_W-1:0] tgt_full;
	logic out_free;

	assign {rd_s, rd_e, rd_t} = ram_rdata;
	assign brk = (rd_s > start_q) ||
		((rd_s == start_q) && ((rd_e > rd_s) || (cmd_q.ramp == '0)));
	assign tgt_full = {seg_t_q, 16'h0000};
	assign diff = MAG_W'(tgt_full) - MAG_W'(f_q);
	assign md_sq = neg_q ? -$signed({1'b0, md_q}) : $signed({1'b0, md_q});
	assign out_free = !out_valid_q || !out_stall;

	srg_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	srg_mdiv #(.TIME_WIDTH(TW)) u_mdiv (
		.clk(clk),
		.arst_n(arst_n),
		.start(md_start),
		.mag(mag_q),
		.num(md_num),
		.den(seg_e_q - seg_s_q),
		.done(md_done),
		.quot(md_q)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (!fifo_stat.empty) state_d = BK_EXEC;
			BK_EXEC: begin
				case (cmd_q.kind)
					CMD_TICK:  state_d = BK_TCHK;
					CMD_SCHED: state_d = BK_SEND;
					default:   state_d = BK_IDLE;
				endcase
			end
			BK_SEND: state_d = BK_SRCH;
			BK_SRCH: state_d = (p_q == count_q) ? BK_IDLE : BK_SCMP;
			BK_SCMP: state_d = brk ? BK_IDLE : BK_SRCH;
			BK_TCHK: state_d = (count_q != '0) ? BK_TRD : BK_TEND;
			BK_TRD:  state_d = (rd_s < tnext_q) ? BK_TSEG : BK_TEND;
			BK_TSEG: state_d = (seg_e_q <= seg_s_q) ? BK_TPOP : BK_TS1;
			BK_TS1:  state_d = BK_TW1;
			BK_TW1:  if (md_done) state_d = BK_TS2;
			BK_TS2:  state_d = BK_TW2;
			BK_TW2:  if (md_done) state_d = BK_TPOP;
			BK_TPOP: state_d = BK_TCHK;
			BK_TEND: state_d = BK_TOUT;
			BK_TOUT: if (out_free) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == BK_IDLE) && !fifo_stat.empty;
		ram_raddr = head_q + p_q[AW-1:0];
		ram_waddr = head_q + p_q[AW-1:0];
		ram_wdata = {start_q, end_q, cmd_q.target};
		ram_we = 1'b0;
		md_start = 1'b0;
		md_num = tnext_q - seg_s_q;
		case (state_q)
			BK_SRCH: ram_we = (p_q == count_q) && (count_q != CMAX);
			BK_SCMP: ram_we = brk;
			BK_TCHK: ram_raddr = head_q;
			BK_TS1:  md_start = 1'b1;
			BK_TS2: begin
				md_start = 1'b1;
				md_num = TW'(ms_per_sample);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			count_q <= '0;
			head_q <= '0;
			cur_q <= '0;
			step_q <= '0;
			at_q <= '0;
			aet_q <= TNEVER;
			now_q <= '0;
			ovf_q <= 1'b0;
			ovf_out_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == BK_TOUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_EXEC: begin
					case (cmd_q.kind)
						CMD_STOP: begin
							count_q <= '0;
							step_q <= '0;
							at_q <= cur_q[VAL_W-1:16];
							aet_q <= TNEVER;
						end
						CMD_JUMP: begin
							cur_q <= {cmd_q.target, 16'h0000};
							count_q <= '0;
							step_q <= '0;
							at_q <= cmd_q.target;
							aet_q <= TNEVER;
						end
						default: begin
						end
					endcase
				end
				BK_SRCH: begin
					if (p_q == count_q) begin
						if (count_q == CMAX) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= p_q + 1'b1;
						end
					end
				end
				BK_SCMP: if (brk) count_q <= p_q + 1'b1;
				BK_TPOP: begin
					at_q <= seg_t_q;
					aet_q <= seg_e_q;
					head_q <= head_q + 1'b1;
					count_q <= count_q - 1'b1;
				end
				BK_TEND: if (aet_q <= tnext_q) aet_q <= TNEVER;
				BK_TOUT: begin
					if (out_free) begin
						// flag travels with the word so later schedules cannot change it
						ovf_out_q <= ovf_q;
						cur_q <= sat48({{2{f_q[VAL_W-1]}}, f_q} +
							{{2{inc_q[VAL_W-1]}}, inc_q});
						step_q <= inc_q;
						now_q <= tnext_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: cmd_q <= head_cmd;
			BK_EXEC: begin
				start_q <= tadd(now_q, TW'(cmd_q.delay));
				p_q <= '0;
				tnext_q <= tadd(now_q, TW'(ms_per_sample));
				f_q <= cur_q;
				inc_q <= step_q;
			end
			BK_SEND: end_q <= tadd(start_q, TW'(cmd_q.ramp));
			BK_SCMP: if (!brk) p_q <= p_q + 1'b1;
			BK_TRD: begin
				seg_s_q <= rd_s;
				seg_e_q <= rd_e;
				seg_t_q <= rd_t;
				// previous ramp already over by the end of this sample period
				if (rd_s < tnext_q && aet_q <= tnext_q) begin
					f_q <= {at_q, 16'h0000};
					inc_q <= '0;
				end
			end
			BK_TSEG: begin
				neg_q <= diff[MAG_W-1];
				mag_q <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
				if (seg_e_q <= seg_s_q) begin
					f_q <= tgt_full;
					inc_q <= '0;
				end
			end
			BK_TW1: begin
				if (md_done) begin
					f_q <= sat48({{2{f_q[VAL_W-1]}}, f_q} + md_sq);
				end
			end
			BK_TW2: if (md_done) inc_q <= sat48(md_sq);
			BK_TEND: begin
				if (aet_q <= tnext_q) begin
					f_q <= {at_q, 16'h0000};
					inc_q <= '0;
				end
			end
			BK_TOUT: begin
				if (out_free) begin
					sample_q <= f_q[VAL_W-1:16];
					ramping_q <= (count_q != '0) || (aet_q != TNEVER);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign sample_value = sample_q;
	assign ramping = ramping_q;
	assign overflow = ovf_out_q;

endmodule

// ----- hdl/srg_checker.sv -----
// port-level checks of the scheduled ramp generator, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] sample_value,
	input logic               ramping,
	input logic               overflow
);

	// output word held while stalled
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(sample_value) && $stable(ramping) && $stable(overflow))
	// overflow is sticky
	`ASSERT_NEXT(a_ovf_sticky, clk, arst_n, out_valid && overflow, overflow)
	// queue only fills right after a word was taken
	`ASSERT_SAME(a_stall_cause, clk, arst_n, $rose(in_stall), $past(in_valid && !in_stall))

endmodule

bind scheduled_ramp_generator srg_checker u_srg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.sample_value(sample_value),
	.ramping(ramping),
	.overflow(overflow)
);
